/* rtl/core/baf_pkg.sv */
// ----------------------------------------------------------------------------
// baf_pkg
// Shared types and constants for the button autofire generator.
// ----------------------------------------------------------------------------
package baf_pkg;

   // Fixed widths of the external fields
   localparam int unsigned BUTTON_W   = 32;
   localparam int unsigned INTERVAL_W = 8;
   localparam int unsigned COUNT_W    = 3;
   localparam int unsigned TSEL_W     = 6;
   localparam int unsigned FSEL_W     = 5;
   localparam int unsigned SEL_FIELDS = 6;
   localparam int unsigned TSEL_ALL_W = TSEL_W * SEL_FIELDS;
   localparam int unsigned FSEL_ALL_W = FSEL_W * SEL_FIELDS;
   localparam int unsigned BIT_IDX_W  = 5;

   // Register indexes on the csr port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRE_INTERVAL  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_COUNT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_SELECT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRE_SELECT    = 2'd3;

   // Per-slot settings handed to one cell
   typedef struct packed {
      logic                 enable;
      logic [BIT_IDX_W-1:0] trigger_idx;
      logic [BIT_IDX_W-1:0] fire_idx;
   } slot_cfg_type;

endpackage

/* rtl/core/baf_cell.sv */
// ----------------------------------------------------------------------------
// baf_cell
// One autofire slot: rewrites the word passing through and keeps its counter.
// ----------------------------------------------------------------------------
module baf_cell #(
   parameter int unsigned WORD_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  baf_pkg::slot_cfg_type            cfg,
   input  logic [baf_pkg::INTERVAL_W-1:0]   fire_interval,
   input  logic                             valid_in,
   input  logic [WORD_BITS-1:0]             word_in,
   output logic                             valid_out,
   output logic [WORD_BITS-1:0]             word_out
);
   import baf_pkg::*;

   logic                  valid_ff, valid_in_d;
   logic [WORD_BITS-1:0]  word_ff, word_in_d;
   logic [INTERVAL_W-1:0] tick_ff, tick_in;
   logic                  phase_ff, phase_in;

   logic [WORD_BITS-1:0]  trig_mask, fire_mask, cleared;
   logic [INTERVAL_W:0]   tick_next;
   logic                  hit, wrap, take;

   // Indexes at or above WORD_BITS select nothing
   assign trig_mask = (32'(cfg.trigger_idx) < WORD_BITS) ?
                      (WORD_BITS'(1) << cfg.trigger_idx) : '0;
   assign fire_mask = (32'(cfg.fire_idx) < WORD_BITS) ?
                      (WORD_BITS'(1) << cfg.fire_idx) : '0;

   assign take      = advance && valid_in;
   assign hit       = cfg.enable && ((word_in & trig_mask) != '0);
   assign tick_next = {1'b0, tick_ff} + (INTERVAL_W+1)'(1);
   assign wrap      = tick_next >= {1'b0, fire_interval};
   assign cleared   = word_in & ~trig_mask;

   always_comb begin
      tick_in  = tick_ff;
      phase_in = phase_ff;
      word_in_d = word_in;
      if (hit) begin
         tick_in  = wrap ? '0 : tick_next[INTERVAL_W-1:0];
         phase_in = phase_ff ^ wrap;
         word_in_d = phase_in ? (cleared & ~fire_mask) : (cleared | fire_mask);
      end else if (cfg.enable) begin
         tick_in  = '0;
         phase_in = 1'b0;
      end
   end

   assign valid_in_d = valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tick_ff  <= '0;
         phase_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in_d;
         if (take) begin
            tick_ff  <= tick_in;
            phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in_d;
      end
   end

   assign valid_out = valid_ff;
   assign word_out  = word_ff;

   // Disabled slot passes the word untouched
   a_disabled_pass : assert property (@(posedge clock) disable iff (reset)
      take && !cfg.enable |=> word_ff == $past(word_in))
      else $error("disabled slot altered the item");

   // Released trigger on an enabled slot clears its state
   a_release_clear : assert property (@(posedge clock) disable iff (reset)
      take && cfg.enable && !hit |=> tick_ff == '0 && !phase_ff)
      else $error("slot state not cleared on release");

   // No item taken, no state change
   a_idle_hold : assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(tick_ff) && $stable(phase_ff))
      else $error("slot state moved without an item");

endmodule

/* rtl/core/button_autofire_generator_unit.sv */
// ----------------------------------------------------------------------------
// button_autofire_generator_unit
// Turbo autofire rewriter: a row of slot cells, one pipeline stage per slot.
// ----------------------------------------------------------------------------
// Pipeline: one registered cell per slot between req acceptance and rsp_valid.
// Throughput: one item per cycle; the whole row of cells moves together and
//   stalls only while the last cell holds a result that rsp_ready refuses.
// Reset: synchronous, active high; clears all pipeline valid bits, every
//   slot's tick counter and phase, and loads the register reset values
//   (fire_interval 1, slot_count 2, both select words 0).
// ----------------------------------------------------------------------------
module button_autofire_generator_unit #(
   parameter int unsigned SLOTS     = 6,
   parameter int unsigned WORD_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [baf_pkg::BUTTON_W-1:0]       req_button_word,
   // Result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [baf_pkg::BUTTON_W-1:0]       rsp_button_result,
   // Register write port
   input  logic                               csr_wr_en,
   input  logic [baf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [baf_pkg::TSEL_ALL_W-1:0]     csr_wdata
);
   import baf_pkg::*;

   // Configuration registers
   logic [INTERVAL_W-1:0] fire_interval_ff;
   logic [COUNT_W-1:0]    slot_count_ff;
   logic [TSEL_ALL_W-1:0] trigger_select_ff;
   logic [FSEL_ALL_W-1:0] fire_select_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fire_interval_ff  <= INTERVAL_W'(1);
         slot_count_ff     <= COUNT_W'(2);
         trigger_select_ff <= '0;
         fire_select_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FIRE_INTERVAL:  fire_interval_ff  <= csr_wdata[INTERVAL_W-1:0];
            CSR_SLOT_COUNT:     slot_count_ff     <= csr_wdata[COUNT_W-1:0];
            CSR_TRIGGER_SELECT: trigger_select_ff <= csr_wdata;
            CSR_FIRE_SELECT:    fire_select_ff    <= csr_wdata[FSEL_ALL_W-1:0];
            default: ;
         endcase
      end
   end

   // Row of cells: stage i sits between link i and link i+1
   logic                 link_valid [SLOTS+1];
   logic [WORD_BITS-1:0] link_word  [SLOTS+1];
   slot_cfg_type         slot_cfg   [SLOTS];
   logic                 advance;

   // Everything moves unless the finished item at the end is held back
   assign advance   = !link_valid[SLOTS] || rsp_ready;
   assign req_ready = advance;

   assign link_valid[0] = req_valid;
   assign link_word[0]  = req_button_word[WORD_BITS-1:0];

   for (genvar i = 0; i < SLOTS; i++) begin : g_slot
      if (i < SEL_FIELDS) begin : g_sel
         // slot active only below slot_count; values above SLOTS saturate naturally
         assign slot_cfg[i].enable      = trigger_select_ff[TSEL_W*i + TSEL_W-1]
                                          && (slot_count_ff > COUNT_W'(i));
         assign slot_cfg[i].trigger_idx = trigger_select_ff[TSEL_W*i +: BIT_IDX_W];
         assign slot_cfg[i].fire_idx    = fire_select_ff[FSEL_W*i +: FSEL_W];
      end else begin : g_nosel
         // no select fields here: the slot is always off
         assign slot_cfg[i] = '0;
      end

      baf_cell #(
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .advance       (advance),
         .cfg           (slot_cfg[i]),
         .fire_interval (fire_interval_ff),
         .valid_in      (link_valid[i]),
         .word_in       (link_word[i]),
         .valid_out     (link_valid[i+1]),
         .word_out      (link_word[i+1])
      );
   end

   assign rsp_valid         = link_valid[SLOTS];
   assign rsp_button_result = BUTTON_W'(link_word[SLOTS]);

   // Bits above the word width never show up in a result
   a_narrow_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_button_result >> WORD_BITS) == '0)
      else $error("result carries bits above the word width");

   // While the row is stalled, the end of the row holds still
   a_row_stall : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(link_valid[SLOTS]) && $stable(rsp_button_result))
      else $error("end of row moved while stalled");

   // A held result must keep the input side blocked
   a_block_in : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item taken while the row is stalled");

endmodule
